/* hdl/cdg_pkg.sv */
// ============================================================================
// cdg_pkg - shared types, constants and tables for the cash dispenser
// Note values, stock presets, reciprocal constants for the greedy divide,
// controller command/status structs and the state encoding.
// ============================================================================
package cdg_pkg;

    localparam int NUM_CURRENCIES_DEF = 4;
    localparam int NUM_DENOMS_DEF     = 7;

    localparam int N_SLOTS = 7;    // note values 5 .. 500
    localparam int D_W     = 3;
    localparam int CUR_W   = 2;
    localparam int CNT_W   = 16;
    localparam int AMT_W   = 20;
    localparam int NOTE_W  = 10;
    localparam int VAL_W   = 10;
    localparam int TOT_W   = 26;   // 885 * 65535 fits
    localparam int QUO_W   = 18;   // (2^20 - 1) / 5 fits
    localparam int REC_W   = 21;
    localparam int PROD_W  = AMT_W + REC_W;
    localparam int SH_W    = 5;
    localparam int STS_W   = 3;

    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = N_SLOTS * CNT_W;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    typedef enum logic [STS_W-1:0] {
        ST_OK        = 3'd0,
        ST_NOT_MULT5 = 3'd1,
        ST_INSUFF    = 3'd2,
        ST_NOT_EXACT = 3'd3,
        ST_BAD_NOTE  = 3'd4,
        ST_FULL      = 3'd5
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_TU_WAIT,
        S_TU_WR,
        S_TOT_WAIT,
        S_TOT_MUL,
        S_TOT_ACC,
        S_CMP,
        S_G_WAIT,
        S_G_DIV,
        S_G_TAKE,
        S_G_SUB,
        S_G_CHK,
        S_CMT,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic    capture;
        logic    tu_idx;
        logic    tot_clr;
        logic    tot_mul;
        logic    tot_acc;
        logic    grd_init;
        logic    grd_div;
        logic    grd_take;
        logic    grd_sub;
        logic    cmt_init;
        logic    cmt_wr;
        logic    tu_wr;
        logic    status_we;
        t_status status;
        logic    out_load;
    } t_cmd;

    typedef struct packed {
        logic is_topup;
        logic note_found;
        logic mod5_ok;
        logic n_zero;
        logic d_last;
        logic d_zero;
        logic total_low;
        logic left_zero;
        logic count_full;
        logic out_busy;
    } t_sts;

    localparam logic [CNT_W-1:0] STOCK_RST [4][N_SLOTS] = '{
        '{16'd200, 16'd150, 16'd110, 16'd80, 16'd60, 16'd40, 16'd20},
        '{16'd110, 16'd90,  16'd70,  16'd40, 16'd30, 16'd20, 16'd10},
        '{16'd110, 16'd90,  16'd70,  16'd40, 16'd30, 16'd0,  16'd0 },
        '{16'd110, 16'd90,  16'd70,  16'd40, 16'd0,  16'd0,  16'd0 }
    };

    function automatic logic [VAL_W-1:0] denom_value(input logic [D_W-1:0] d);
        logic [VAL_W-1:0] v;
        case (d)
            3'd0:    v = 10'd5;
            3'd1:    v = 10'd10;
            3'd2:    v = 10'd20;
            3'd3:    v = 10'd50;
            3'd4:    v = 10'd100;
            3'd5:    v = 10'd200;
            3'd6:    v = 10'd500;
            default: v = 10'd0;
        endcase
        return v;
    endfunction

    // quotient = (x * mult) >> shift, exact for any 20-bit x
    function automatic logic [REC_W-1:0] div_mult(input logic [D_W-1:0] d);
        logic [REC_W-1:0] m;
        case (d)
            3'd0, 3'd1, 3'd2: m = 21'd1677722;
            3'd3, 3'd4, 3'd5: m = 21'd1342178;
            3'd6:             m = 21'd1073742;
            default:          m = 21'd0;
        endcase
        return m;
    endfunction

    function automatic logic [SH_W-1:0] div_shift(input logic [D_W-1:0] d);
        logic [SH_W-1:0] s;
        case (d)
            3'd0:    s = 5'd23;
            3'd1:    s = 5'd24;
            3'd2:    s = 5'd25;
            3'd3:    s = 5'd26;
            3'd4:    s = 5'd27;
            3'd5:    s = 5'd28;
            3'd6:    s = 5'd29;
            default: s = 5'd0;
        endcase
        return s;
    endfunction

    function automatic logic [D_W-1:0] denoms_of(input logic [CUR_W-1:0] cur);
        logic [D_W-1:0] n;
        case (cur)
            2'd0, 2'd1: n = 3'd7;
            2'd2:       n = 3'd5;
            default:    n = 3'd4;
        endcase
        return n;
    endfunction

    function automatic logic [D_W-1:0] usable_denoms(input logic [CUR_W-1:0] cur,
                                                     input int num_cur,
                                                     input int num_den);
        logic [D_W-1:0] n;
        n = denoms_of(cur);
        if (int'(cur) >= num_cur) begin
            n = '0;
        end else if (int'(n) > num_den) begin
            n = D_W'(num_den);
        end
        return n;
    endfunction

    function automatic logic [CNT_W-1:0] stock_reset(input logic [CUR_W-1:0] cur,
                                                     input logic [D_W-1:0] d);
        logic [CNT_W-1:0] v;
        v = '0;
        if (int'(d) < N_SLOTS) begin
            v = STOCK_RST[cur][d];
        end
        return v;
    endfunction

    // 16 is 1 mod 5: fold nibbles, then fold once more
    function automatic logic is_mult5(input logic [AMT_W-1:0] amount);
        logic [6:0] s;
        logic [4:0] t;
        s = '0;
        for (int i = 0; i < AMT_W / 4; i++) begin
            s = s + 7'(amount[4*i +: 4]);
        end
        t = 5'(s[6:4]) + 5'(s[3:0]);
        return t inside {5'd0, 5'd5, 5'd10, 5'd15};
    endfunction

endpackage

/* hdl/cdg_store.sv */
// ============================================================================
// cdg_store - note stock memory
// One entry per currency and note value, one address shared by read and write,
// registered read. Per-entry valid bits make unwritten entries read as the
// preset stock.
// ============================================================================
module cdg_store #(
    parameter int NUM_CURRENCIES = cdg_pkg::NUM_CURRENCIES_DEF,
    parameter int NUM_DENOMS     = cdg_pkg::NUM_DENOMS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [cdg_pkg::CUR_W-1:0]  i_cur,
    input  logic [cdg_pkg::D_W-1:0]    i_d,
    input  logic                       i_we,
    input  logic [cdg_pkg::CNT_W-1:0]  i_wdata,
    output logic [cdg_pkg::CNT_W-1:0]  o_rdata
);
    import cdg_pkg::*;

    localparam int DEPTH  = NUM_CURRENCIES * NUM_DENOMS;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FULL_W = CUR_W + D_W + 2;

    logic [CNT_W-1:0]  r_mem [DEPTH];
    logic [DEPTH-1:0]  r_valid;
    logic [CNT_W-1:0]  r_rd_mem;
    logic [CNT_W-1:0]  r_rd_rst;
    logic              r_rd_vld;

    logic [FULL_W-1:0] w_full;
    logic              w_hit;
    logic [ADDR_W-1:0] w_addr;

    assign w_full = FULL_W'(i_cur) * FULL_W'(NUM_DENOMS) + FULL_W'(i_d);
    assign w_hit  = (w_full < FULL_W'(DEPTH));
    assign w_addr = w_hit ? w_full[ADDR_W-1:0] : '0;

    always_ff @(posedge i_clk) begin
        if (i_we && w_hit) begin
            r_mem[w_addr] <= i_wdata;
        end
        r_rd_mem <= r_mem[w_addr];
        r_rd_rst <= stock_reset(i_cur, i_d);
        r_rd_vld <= r_valid[w_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_we && w_hit) begin
            r_valid[w_addr] <= 1'b1;
        end
    end

    assign o_rdata = r_rd_vld ? r_rd_mem : r_rd_rst;

endmodule

/* hdl/cdg_datapath.sv */
// ============================================================================
// cdg_datapath - request registers, arithmetic and result register
// Walks the stock one note value at a time: value total, greedy take by
// reciprocal divide, then write-back of the reduced counts. A top-up adds one note.
// ============================================================================
module cdg_datapath #(
    parameter int NUM_CURRENCIES = cdg_pkg::NUM_CURRENCIES_DEF,
    parameter int NUM_DENOMS     = cdg_pkg::NUM_DENOMS_DEF
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  logic                                       i_req_type,
    input  logic [cdg_pkg::CUR_W-1:0]                  i_currency,
    input  logic [cdg_pkg::AMT_W-1:0]                  i_amount,
    input  logic [cdg_pkg::NOTE_W-1:0]                 i_note_value,
    input  cdg_pkg::t_cmd                              i_cmd,
    output cdg_pkg::t_sts                              o_sts,
    input  logic                                       i_out_ready,
    output logic                                       o_out_valid,
    output cdg_pkg::t_status                           o_status,
    output logic [cdg_pkg::N_SLOTS-1:0][cdg_pkg::CNT_W-1:0] o_given
);
    import cdg_pkg::*;

    localparam int SUB_W = CNT_W + VAL_W;

    logic                 r_req;
    logic [CUR_W-1:0]     r_cur;
    logic [AMT_W-1:0]     r_amount;
    logic [NOTE_W-1:0]    r_note;
    logic [D_W-1:0]       r_n;
    logic [D_W-1:0]       r_d;
    logic [TOT_W-1:0]     r_total;
    logic [TOT_W-1:0]     r_prod;
    logic [AMT_W-1:0]     r_left;
    logic [QUO_W-1:0]     r_q;
    logic [CNT_W-1:0]     r_have;
    logic [CNT_W-1:0]     r_tk;
    logic [CNT_W-1:0]     r_take [N_SLOTS];
    logic [CNT_W-1:0]     r_rem  [N_SLOTS];
    t_status              r_status;
    logic                 r_out_valid;
    t_status              r_out_status;
    logic [N_SLOTS-1:0][CNT_W-1:0] r_out_given;

    logic [CNT_W-1:0]     w_rdata;
    logic                 w_we;
    logic [CNT_W-1:0]     w_wdata;
    logic                 w_found;
    logic [D_W-1:0]       w_note_idx;
    logic [D_W-1:0]       w_d_top;
    logic [PROD_W-1:0]    w_qprod;
    logic [CNT_W-1:0]     w_take;
    logic [SUB_W-1:0]     w_sub;
    logic                 w_full;

    cdg_store #(
        .NUM_CURRENCIES (NUM_CURRENCIES),
        .NUM_DENOMS     (NUM_DENOMS)
    ) u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cur   (r_cur),
        .i_d     (r_d),
        .i_we    (w_we),
        .i_wdata (w_wdata),
        .o_rdata (w_rdata)
    );

    assign w_full  = (w_rdata == CNT_MAX);
    assign w_we    = i_cmd.cmt_wr | (i_cmd.tu_wr & ~w_full);
    assign w_wdata = i_cmd.cmt_wr ? r_rem[r_d] : w_rdata + CNT_W'(1);
    assign w_d_top = r_n - D_W'(1);

    always_comb begin
        w_found    = 1'b0;
        w_note_idx = '0;
        for (int i = 0; i < N_SLOTS; i++) begin
            if (!w_found && D_W'(i) < r_n && denom_value(D_W'(i)) == r_note) begin
                w_found    = 1'b1;
                w_note_idx = D_W'(i);
            end
        end
    end

    assign w_qprod = PROD_W'(r_left) * PROD_W'(div_mult(r_d));
    assign w_take  = (r_q < QUO_W'(r_have)) ? CNT_W'(r_q) : r_have;
    assign w_sub   = SUB_W'(r_tk) * SUB_W'(denom_value(r_d));

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_req    <= i_req_type;
            r_cur    <= i_currency;
            r_amount <= i_amount;
            r_note   <= i_note_value;
            r_n      <= usable_denoms(i_currency, NUM_CURRENCIES, NUM_DENOMS);
            for (int i = 0; i < N_SLOTS; i++) begin
                r_take[i] <= '0;
            end
        end
        if (i_cmd.tu_idx) begin
            r_d <= w_note_idx;
        end
        if (i_cmd.tot_clr) begin
            r_total <= '0;
            r_d     <= '0;
        end
        if (i_cmd.tot_mul) begin
            r_prod <= TOT_W'(denom_value(r_d)) * TOT_W'(w_rdata);
        end
        if (i_cmd.tot_acc) begin
            r_total <= r_total + r_prod;
            r_d     <= r_d + D_W'(1);
        end
        if (i_cmd.grd_init) begin
            r_left <= r_amount;
            r_d    <= w_d_top;
        end
        if (i_cmd.grd_div) begin
            r_q    <= QUO_W'(w_qprod >> div_shift(r_d));
            r_have <= w_rdata;
        end
        if (i_cmd.grd_take) begin
            r_tk        <= w_take;
            r_take[r_d] <= w_take;
            r_rem[r_d]  <= r_have - w_take;
        end
        if (i_cmd.grd_sub) begin
            r_left <= r_left - AMT_W'(w_sub);
            if (r_d != '0) begin
                r_d <= r_d - D_W'(1);
            end
        end
        if (i_cmd.cmt_init) begin
            r_d <= '0;
        end
        if (i_cmd.cmt_wr) begin
            r_d <= r_d + D_W'(1);
        end
        if (i_cmd.status_we) begin
            r_status <= i_cmd.status;
        end
        if (i_cmd.out_load) begin
            r_out_status <= r_status;
            for (int i = 0; i < N_SLOTS; i++) begin
                r_out_given[i] <= (r_status == ST_OK) ? r_take[i] : '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_comb begin
        o_sts.is_topup   = r_req;
        o_sts.note_found = w_found;
        o_sts.mod5_ok    = is_mult5(r_amount);
        o_sts.n_zero     = (r_n == '0);
        o_sts.d_last     = (r_d == w_d_top);
        o_sts.d_zero     = (r_d == '0);
        o_sts.total_low  = (r_total < TOT_W'(r_amount));
        o_sts.left_zero  = (r_left == '0);
        o_sts.count_full = w_full;
        o_sts.out_busy   = r_out_valid & ~i_out_ready;
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_out_status;
    assign o_given     = r_out_given;

endmodule

/* hdl/cdg_ctrl.sv */
// ============================================================================
// cdg_ctrl - request sequencer
// Steps the datapath through validation, stock total, greedy pass and
// write-back, then hands the result to the output register.
// ============================================================================
module cdg_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  cdg_pkg::t_sts i_sts,
    output cdg_pkg::t_cmd o_cmd
);
    import cdg_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_DECODE;
            end
            S_DECODE: begin
                if (i_sts.is_topup) begin
                    n_state = i_sts.note_found ? S_TU_WAIT : S_FINISH;
                end else if (!i_sts.mod5_ok) begin
                    n_state = S_FINISH;
                end else begin
                    n_state = i_sts.n_zero ? S_CMP : S_TOT_WAIT;
                end
            end
            S_TU_WAIT:  n_state = S_TU_WR;
            S_TU_WR:    n_state = S_FINISH;
            S_TOT_WAIT: n_state = S_TOT_MUL;
            S_TOT_MUL:  n_state = S_TOT_ACC;
            S_TOT_ACC: begin
                n_state = i_sts.d_last ? S_CMP : S_TOT_WAIT;
            end
            S_CMP: begin
                if (i_sts.total_low || i_sts.n_zero) begin
                    n_state = S_FINISH;
                end else begin
                    n_state = S_G_WAIT;
                end
            end
            S_G_WAIT: n_state = S_G_DIV;
            S_G_DIV:  n_state = S_G_TAKE;
            S_G_TAKE: n_state = S_G_SUB;
            S_G_SUB: begin
                n_state = i_sts.d_zero ? S_G_CHK : S_G_WAIT;
            end
            S_G_CHK: begin
                n_state = i_sts.left_zero ? S_CMT : S_FINISH;
            end
            S_CMT: begin
                if (i_sts.d_last) n_state = S_FINISH;
            end
            S_FINISH: begin
                if (!i_sts.out_busy) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd        = '0;
        o_cmd.status = ST_OK;
        o_in_ready   = (r_state == S_IDLE);
        case (r_state)
            S_IDLE: begin
                o_cmd.capture = i_in_valid;
            end
            S_DECODE: begin
                if (i_sts.is_topup) begin
                    if (i_sts.note_found) begin
                        o_cmd.tu_idx = 1'b1;
                    end else begin
                        o_cmd.status_we = 1'b1;
                        o_cmd.status    = ST_BAD_NOTE;
                    end
                end else if (!i_sts.mod5_ok) begin
                    o_cmd.status_we = 1'b1;
                    o_cmd.status    = ST_NOT_MULT5;
                end else begin
                    o_cmd.tot_clr = 1'b1;
                end
            end
            S_TU_WR: begin
                o_cmd.tu_wr     = 1'b1;
                o_cmd.status_we = 1'b1;
                o_cmd.status    = i_sts.count_full ? ST_FULL : ST_OK;
            end
            S_TOT_MUL: o_cmd.tot_mul = 1'b1;
            S_TOT_ACC: o_cmd.tot_acc = 1'b1;
            S_CMP: begin
                if (i_sts.total_low) begin
                    o_cmd.status_we = 1'b1;
                    o_cmd.status    = ST_INSUFF;
                end else begin
                    // nothing to walk: only a zero amount gets here
                    o_cmd.grd_init = 1'b1;
                    if (i_sts.n_zero) begin
                        o_cmd.status_we = 1'b1;
                        o_cmd.status    = ST_OK;
                    end
                end
            end
            S_G_DIV:  o_cmd.grd_div  = 1'b1;
            S_G_TAKE: o_cmd.grd_take = 1'b1;
            S_G_SUB:  o_cmd.grd_sub  = 1'b1;
            S_G_CHK: begin
                if (i_sts.left_zero) begin
                    o_cmd.cmt_init = 1'b1;
                end else begin
                    o_cmd.status_we = 1'b1;
                    o_cmd.status    = ST_NOT_EXACT;
                end
            end
            S_CMT: begin
                o_cmd.cmt_wr = 1'b1;
                if (i_sts.d_last) begin
                    o_cmd.status_we = 1'b1;
                    o_cmd.status    = ST_OK;
                end
            end
            S_FINISH: begin
                o_cmd.out_load = ~i_sts.out_busy;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

/* hdl/cash_dispense_greedy.sv */
// Sequencing: a top-up reads one stock count and writes it back incremented unless full;
// a withdraw walks the N note values of the currency for the total, the greedy
// pass and the write-back, one note value per step on the single stock port.
// Requests: one in flight; the next is taken in the cycle after the result is
// handed to the output register, even while that result waits.
// Reset (synchronous, active low) restores the preset stock at once.
// ============================================================================
// cash_dispense_greedy - cash dispenser with limited note stock
// Withdraw by greedy largest-note-first selection with exact-sum check,
// or top up one note of a valid value.
// ============================================================================
module cash_dispense_greedy #(
    parameter int NUM_CURRENCIES = cdg_pkg::NUM_CURRENCIES_DEF,
    parameter int NUM_DENOMS     = cdg_pkg::NUM_DENOMS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // currency[1:0], amount[21:2], note_value[31:22]
    input  logic [cdg_pkg::S_TDATA_W-1:0]     i_s_axis_tdata,
    // req_type[0]
    input  logic                              i_s_axis_tuser,
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // given_5[15:0], given_10[31:16], given_20[47:32], given_50[63:48],
    // given_100[79:64], given_200[95:80], given_500[111:96]
    output logic [cdg_pkg::M_TDATA_W-1:0]     o_m_axis_tdata,
    // status[2:0]
    output logic [cdg_pkg::STS_W-1:0]         o_m_axis_tuser
);
    import cdg_pkg::*;

    t_cmd                          w_cmd;
    t_sts                          w_sts;
    t_status                       w_status;
    logic [N_SLOTS-1:0][CNT_W-1:0] w_given;

    cdg_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    cdg_datapath #(
        .NUM_CURRENCIES (NUM_CURRENCIES),
        .NUM_DENOMS     (NUM_DENOMS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_type   (i_s_axis_tuser),
        .i_currency   (i_s_axis_tdata[CUR_W-1:0]),
        .i_amount     (i_s_axis_tdata[CUR_W +: AMT_W]),
        .i_note_value (i_s_axis_tdata[CUR_W+AMT_W +: NOTE_W]),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .i_out_ready  (i_m_axis_tready),
        .o_out_valid  (o_m_axis_tvalid),
        .o_status     (w_status),
        .o_given      (w_given)
    );

    assign o_m_axis_tdata = w_given;
    assign o_m_axis_tuser = w_status;

endmodule
